[src/slx_pkg.sv]
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types, token kind codes and character classes for the byte-stream
// lexer.
// ----------------------------------------------------------------------------
package slx_pkg;

    // output queue geometry
    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    typedef logic [5:0] kind_t;

    // token kind codes
    localparam kind_t K_CHAR    = 6'd0;
    localparam kind_t K_END     = 6'd1;
    localparam kind_t K_COLON   = 6'd2;
    localparam kind_t K_COMMA   = 6'd3;
    localparam kind_t K_DOT     = 6'd4;
    localparam kind_t K_LPAREN  = 6'd5;
    localparam kind_t K_RPAREN  = 6'd6;
    localparam kind_t K_LBRACK  = 6'd7;
    localparam kind_t K_RBRACK  = 6'd8;
    localparam kind_t K_LBRACE  = 6'd9;
    localparam kind_t K_RBRACE  = 6'd10;
    localparam kind_t K_PLUS    = 6'd11;
    localparam kind_t K_MINUS   = 6'd12;
    localparam kind_t K_STAR    = 6'd13;
    localparam kind_t K_SLASH   = 6'd14;
    localparam kind_t K_PERCENT = 6'd15;
    localparam kind_t K_AMP     = 6'd16;
    localparam kind_t K_PIPE    = 6'd17;
    localparam kind_t K_CARET   = 6'd18;
    localparam kind_t K_TILDE   = 6'd19;
    localparam kind_t K_AT      = 6'd20;
    localparam kind_t K_ATAT    = 6'd21;
    localparam kind_t K_CEQ     = 6'd22;
    localparam kind_t K_RET     = 6'd23;
    localparam kind_t K_NOT     = 6'd24;
    localparam kind_t K_CNE     = 6'd25;
    localparam kind_t K_CLT     = 6'd26;
    localparam kind_t K_CLE     = 6'd27;
    localparam kind_t K_BLS     = 6'd28;
    localparam kind_t K_CGT     = 6'd29;
    localparam kind_t K_CGE     = 6'd30;
    localparam kind_t K_BRS     = 6'd31;
    localparam kind_t K_INT     = 6'd32;
    localparam kind_t K_DBL     = 6'd33;
    localparam kind_t K_IDENT   = 6'd34;
    localparam kind_t K_STR     = 6'd35;
    localparam kind_t K_ERR     = 6'd36;

    // characters of interest
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_RBRC   = 8'h7D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    // unescaped byte values
    localparam logic [7:0] BY_NUL = 8'h00;
    localparam logic [7:0] BY_BEL = 8'h07;
    localparam logic [7:0] BY_BS  = 8'h08;
    localparam logic [7:0] BY_TAB = 8'h09;
    localparam logic [7:0] BY_FF  = 8'h0C;
    localparam logic [7:0] BY_CR  = 8'h0D;

    typedef enum logic [3:0] {
        ST_BEGIN   = 4'd0,
        ST_AT      = 4'd1,
        ST_NOT     = 4'd2,
        ST_LT      = 4'd3,
        ST_GT      = 4'd4,
        ST_EQ      = 4'd5,
        ST_COMMENT = 4'd6,
        ST_INT     = 4'd7,
        ST_DBL     = 4'd8,
        ST_IDENT   = 4'd9,
        ST_STR     = 4'd10,
        ST_ESC     = 4'd11
    } lex_state_t;

    // one output word
    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        logic       last;
    } item_t;

    // everything one byte produces
    typedef struct packed {
        logic [1:0] count;
        item_t      item0;
        item_t      item1;
    } step_t;

    // outcome of handling a byte from the begin state
    typedef struct packed {
        lex_state_t state;
        logic       emit;
        item_t      item;
    } begin_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return (c == CH_UNDER) || is_alpha(c) || is_digit(c);
    endfunction

    // kind of a one-character token, K_CHAR when there is none
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            CH_DOLLAR: k = K_END;
            CH_COLON:  k = K_COLON;
            CH_COMMA:  k = K_COMMA;
            CH_DOT:    k = K_DOT;
            CH_LPAR:   k = K_LPAREN;
            CH_RPAR:   k = K_RPAREN;
            CH_LBRK:   k = K_LBRACK;
            CH_RBRK:   k = K_RBRACK;
            CH_LBRC:   k = K_LBRACE;
            CH_RBRC:   k = K_RBRACE;
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_STAR:   k = K_STAR;
            CH_SLASH:  k = K_SLASH;
            CH_PCT:    k = K_PERCENT;
            CH_AMP:    k = K_AMP;
            CH_PIPE:   k = K_PIPE;
            CH_CARET:  k = K_CARET;
            CH_TILDE:  k = K_TILDE;
            default:   k = K_CHAR;
        endcase
        return k;
    endfunction

    function automatic item_t make_item(input kind_t k, input logic [7:0] c);
        item_t it;
        it.kind = k;
        it.ch   = c;
        it.last = 1'b0;
        return it;
    endfunction

    // a byte seen from the begin state
    function automatic begin_t from_begin(input logic [7:0] c);
        begin_t r;
        kind_t  k;
        k      = single_kind(c);
        r.state = ST_BEGIN;
        r.emit  = 1'b0;
        r.item  = make_item(k, 8'h00);
        if (k != K_CHAR) begin
            r.emit = 1'b1;
        end else begin
            case (c)
                CH_HASH:  r.state = ST_COMMENT;
                CH_AT:    r.state = ST_AT;
                CH_QUOTE: r.state = ST_STR;
                CH_EQ:    r.state = ST_EQ;
                CH_BANG:  r.state = ST_NOT;
                CH_LT:    r.state = ST_LT;
                CH_GT:    r.state = ST_GT;
                default:
                begin
                    if (is_digit(c)) begin
                        r.state = ST_INT;
                        r.emit  = 1'b1;
                        r.item  = make_item(K_CHAR, c);
                    end else if (c == CH_UNDER || is_alpha(c)) begin
                        r.state = ST_IDENT;
                        r.emit  = 1'b1;
                        r.item  = make_item(K_CHAR, c);
                    end
                end
            endcase
        end
        return r;
    endfunction

endpackage

[src/slx_core.sv]
// ----------------------------------------------------------------------------
// slx_core
// Lexer state register and the per-byte decode that yields up to two words.
// ----------------------------------------------------------------------------
module slx_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                end_of_input,
    output slx_pkg::step_t      step
);

    slx_pkg::lex_state_t state_reg;
    slx_pkg::lex_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= slx_pkg::ST_BEGIN;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // decode of one byte
    always_comb
    begin
        slx_pkg::step_t  s;
        slx_pkg::begin_t fb;
        slx_pkg::kind_t  fin;
        logic            finish;
        logic            esc_ok;
        logic [7:0]      esc_val;

        s.count    = 2'd0;
        s.item0    = slx_pkg::make_item(slx_pkg::K_CHAR, 8'h00);
        s.item1    = slx_pkg::make_item(slx_pkg::K_CHAR, 8'h00);
        state_next = state_reg;
        finish     = 1'b0;
        fin        = slx_pkg::K_CHAR;
        fb         = slx_pkg::from_begin(in_byte);
        esc_ok     = 1'b1;
        esc_val    = 8'h00;

        if (end_of_input) begin
            // flush a pending token, then END
            s.count = 2'd2;
            unique case (state_reg)
                slx_pkg::ST_AT:    fin = slx_pkg::K_AT;
                slx_pkg::ST_EQ:    fin = slx_pkg::K_CEQ;
                slx_pkg::ST_NOT:   fin = slx_pkg::K_NOT;
                slx_pkg::ST_LT:    fin = slx_pkg::K_CLT;
                slx_pkg::ST_GT:    fin = slx_pkg::K_CGT;
                slx_pkg::ST_INT:   fin = slx_pkg::K_INT;
                slx_pkg::ST_DBL:   fin = slx_pkg::K_DBL;
                slx_pkg::ST_IDENT: fin = slx_pkg::K_IDENT;
                slx_pkg::ST_STR,
                slx_pkg::ST_ESC:   fin = slx_pkg::K_ERR;
                default:           s.count = 2'd1;
            endcase
            if (s.count == 2'd2) begin
                s.item0 = slx_pkg::make_item(fin, 8'h00);
                s.item1 = slx_pkg::make_item(slx_pkg::K_END, 8'h00);
            end else begin
                s.item0 = slx_pkg::make_item(slx_pkg::K_END, 8'h00);
            end
            state_next = slx_pkg::ST_BEGIN;
        end else begin
            unique case (state_reg)
                slx_pkg::ST_AT:
                begin
                    if (in_byte == slx_pkg::CH_AT) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_ATAT, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else begin
                        finish = 1'b1;
                        fin    = slx_pkg::K_AT;
                    end
                end
                slx_pkg::ST_EQ:
                begin
                    if (in_byte == slx_pkg::CH_GT) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_RET, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else begin
                        finish = 1'b1;
                        fin    = slx_pkg::K_CEQ;
                    end
                end
                slx_pkg::ST_NOT:
                begin
                    if (in_byte == slx_pkg::CH_EQ) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_CNE, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else begin
                        finish = 1'b1;
                        fin    = slx_pkg::K_NOT;
                    end
                end
                slx_pkg::ST_LT:
                begin
                    if (in_byte == slx_pkg::CH_EQ) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_CLE, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else if (in_byte == slx_pkg::CH_LT) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_BLS, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else begin
                        finish = 1'b1;
                        fin    = slx_pkg::K_CLT;
                    end
                end
                slx_pkg::ST_GT:
                begin
                    if (in_byte == slx_pkg::CH_EQ) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_CGE, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else if (in_byte == slx_pkg::CH_GT) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_BRS, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else begin
                        finish = 1'b1;
                        fin    = slx_pkg::K_CGT;
                    end
                end
                slx_pkg::ST_COMMENT:
                begin
                    if (in_byte == slx_pkg::CH_NL) begin
                        state_next = slx_pkg::ST_BEGIN;
                    end
                end
                slx_pkg::ST_INT:
                begin
                    if (in_byte == slx_pkg::CH_DOT) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_CHAR, in_byte);
                        state_next = slx_pkg::ST_DBL;
                    end else if (slx_pkg::is_digit(in_byte)) begin
                        s.count = 2'd1;
                        s.item0 = slx_pkg::make_item(slx_pkg::K_CHAR, in_byte);
                    end else begin
                        finish = 1'b1;
                        fin    = slx_pkg::K_INT;
                    end
                end
                slx_pkg::ST_DBL:
                begin
                    if (slx_pkg::is_digit(in_byte)) begin
                        s.count = 2'd1;
                        s.item0 = slx_pkg::make_item(slx_pkg::K_CHAR, in_byte);
                    end else begin
                        finish = 1'b1;
                        fin    = slx_pkg::K_DBL;
                    end
                end
                slx_pkg::ST_IDENT:
                begin
                    if (slx_pkg::is_word(in_byte)) begin
                        s.count = 2'd1;
                        s.item0 = slx_pkg::make_item(slx_pkg::K_CHAR, in_byte);
                    end else begin
                        finish = 1'b1;
                        fin    = slx_pkg::K_IDENT;
                    end
                end
                slx_pkg::ST_STR:
                begin
                    if (in_byte == slx_pkg::CH_NL) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_ERR, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else if (in_byte == slx_pkg::CH_BSLASH) begin
                        state_next = slx_pkg::ST_ESC;
                    end else if (in_byte == slx_pkg::CH_QUOTE) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_STR, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else begin
                        s.count = 2'd1;
                        s.item0 = slx_pkg::make_item(slx_pkg::K_CHAR, in_byte);
                    end
                end
                slx_pkg::ST_ESC:
                begin
                    case (in_byte)
                        slx_pkg::CH_LO_N:   esc_val = slx_pkg::CH_NL;
                        slx_pkg::CH_BSLASH: esc_val = slx_pkg::CH_BSLASH;
                        slx_pkg::CH_QUOTE:  esc_val = slx_pkg::CH_QUOTE;
                        slx_pkg::CH_LO_A:   esc_val = slx_pkg::BY_BEL;
                        slx_pkg::CH_LO_B:   esc_val = slx_pkg::BY_BS;
                        slx_pkg::CH_ZERO:   esc_val = slx_pkg::BY_NUL;
                        slx_pkg::CH_LO_T:   esc_val = slx_pkg::BY_TAB;
                        slx_pkg::CH_LO_R:   esc_val = slx_pkg::BY_CR;
                        slx_pkg::CH_LO_F:   esc_val = slx_pkg::BY_FF;
                        default:            esc_ok  = 1'b0;
                    endcase
                    if (in_byte == slx_pkg::CH_NL) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_ERR, 8'h00);
                        state_next = slx_pkg::ST_BEGIN;
                    end else if (esc_ok) begin
                        s.count    = 2'd1;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_CHAR, esc_val);
                        state_next = slx_pkg::ST_STR;
                    end else begin
                        // unknown escape keeps the backslash
                        s.count    = 2'd2;
                        s.item0    = slx_pkg::make_item(slx_pkg::K_CHAR, slx_pkg::CH_BSLASH);
                        s.item1    = slx_pkg::make_item(slx_pkg::K_CHAR, in_byte);
                        state_next = slx_pkg::ST_STR;
                    end
                end
                default:
                begin
                    s.count    = fb.emit ? 2'd1 : 2'd0;
                    s.item0    = fb.item;
                    state_next = fb.state;
                end
            endcase

            // token ended by this byte: send its kind, rerun byte from begin
            if (finish) begin
                s.item0    = slx_pkg::make_item(fin, 8'h00);
                s.item1    = fb.item;
                s.count    = fb.emit ? 2'd2 : 2'd1;
                state_next = fb.state;
            end
        end

        // mark the final word of the run
        if (s.count == 2'd2) begin
            s.item1.last = 1'b1;
        end else if (s.count == 2'd1) begin
            s.item0.last = 1'b1;
        end
        step = s;
    end

endmodule

[src/script_lexer_byte_stream.sv]
// ----------------------------------------------------------------------------
// script_lexer_byte_stream
// Byte-stream lexer: source bytes in, token words out through a short queue.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle while in_ready is high. Each byte is
// decoded in the cycle it is accepted and produces zero, one or two words,
// which are written straight into a four-word output queue; if it was empty,
// the first word shows on the output in the next cycle. in_ready is high
// while the queue has at least two free places, so a stream of bytes flows
// at one per cycle as long as the consumer takes one word per cycle; only the
// rare two-word bytes build up the queue, drained one per out_ready cycle.
module script_lexer_byte_stream
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                end_of_input,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [5:0]          item_kind,
    output logic [7:0]          value_char,
    output logic                last_of_run
);

    localparam int DEPTH = slx_pkg::OUT_DEPTH;
    localparam int PW    = slx_pkg::PTR_W;
    localparam int CW    = slx_pkg::CNT_W;

    slx_pkg::step_t step;
    slx_pkg::item_t queue_mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic          accept;
    logic          pop;
    logic [CW-1:0] push_n;

    // handshakes
    assign in_ready  = (count_reg <= CW'(DEPTH - 2));
    assign accept    = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign push_n    = accept ? CW'(step.count) : '0;

    // lexer decode
    slx_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .step         (step)
    );

    // queue pointers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_n);
        rd_ptr_next = rd_ptr_reg + (pop ? PW'(1) : PW'(0));
        count_next  = count_reg + push_n - (pop ? CW'(1) : CW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept && step.count != 2'd0) begin
            queue_mem[wr_ptr_reg] <= step.item0;
        end
        if (accept && step.count == 2'd2) begin
            queue_mem[wr_ptr_reg + PW'(1)] <= step.item1;
        end
    end

    // head word
    assign item_kind   = queue_mem[rd_ptr_reg].kind;
    assign value_char  = queue_mem[rd_ptr_reg].ch;
    assign last_of_run = queue_mem[rd_ptr_reg].last;

endmodule

[src/slx_checker.sv]
// ----------------------------------------------------------------------------
// slx_checker
// Port-level checks for the byte-stream lexer, bound to the top level.
// ----------------------------------------------------------------------------
module slx_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_input,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [5:0]  item_kind,
    input  logic [7:0]  value_char,
    input  logic        last_of_run
);

    // an offered input word holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_byte)
            && $stable(end_of_input))
        else $error("input word changed while stalled");

    // a pending output word holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_kind)
            && $stable(value_char) && $stable(last_of_run))
        else $error("output word changed while stalled");

    // an empty queue never stalls the input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output queue");

    // end of text always produces a word on the next cycle
    a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_input |=> out_valid)
        else $error("no word after end of text");

    // token words carry no character and a known kind
    a_kind_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind != slx_pkg::K_CHAR |-> value_char == 8'h00
            && item_kind <= slx_pkg::K_ERR)
        else $error("bad token word");

endmodule

bind script_lexer_byte_stream slx_checker u_slx_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .item_kind    (item_kind),
    .value_char   (value_char),
    .last_of_run  (last_of_run)
);
